// ===== hdl/b32m_pkg.sv =====
// types and constants shared by the binary32 multiplier pipeline
package b32m_pkg;

	localparam logic [31:0] DEFAULT_NAN = 32'h7fc0_0000;
	localparam logic [31:0] INF_BITS    = 32'h7f80_0000;
	localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
	localparam int unsigned EXP_BIAS    = 127;

	typedef enum logic [1:0] {
		SPC_NONE,
		SPC_FIXED
	} spc_t;

	typedef struct packed {
		logic        sign;
		spc_t        spc;
		logic [31:0] fixed;
		logic signed [10:0] expo;
		logic [23:0] sig_a;
		logic [23:0] sig_b;
	} unp_t;

	typedef struct packed {
		logic        sign;
		spc_t        spc;
		logic [31:0] fixed;
		logic signed [10:0] expo;
		logic [47:0] prod;
	} mul_t;

	// count of leading zeros in a 23-bit fraction (input is nonzero)
	function automatic logic [4:0] lzc23(input logic [22:0] f);
		logic [4:0] n;
		logic       found;
		n = 5'd0;
		found = 1'b0;
		for (int i = 22; i >= 0; i--) begin
			if (!found && f[i]) begin
				n = 5'(22 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

// ===== hdl/b32m_unpack.sv =====
// stage one: special-case detection and operand normalization
module b32m_unpack import b32m_pkg::*; (
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output unp_t        unp
);
	logic [7:0]  ea, eb;
	logic [22:0] fa, fb;
	logic        a_zero, b_zero, a_nan, b_nan, a_inf, b_inf, sign;
	logic [4:0]  la, lb;
	logic signed [10:0] xa, xb;
	logic [23:0] sa, sb;

	always_comb begin
		ea = operand_a[30:23];
		eb = operand_b[30:23];
		fa = operand_a[22:0];
		fb = operand_b[22:0];
		sign = operand_a[31] ^ operand_b[31];
		a_zero = (ea == 8'd0) && (fa == 23'd0);
		b_zero = (eb == 8'd0) && (fb == 23'd0);
		a_nan = (ea == 8'hff) && (fa != 23'd0);
		b_nan = (eb == 8'hff) && (fb != 23'd0);
		a_inf = (ea == 8'hff);
		b_inf = (eb == 8'hff);
		la = lzc23(fa);
		lb = lzc23(fb);
		if (ea != 8'd0) begin
			sa = {1'b1, fa};
			xa = 11'(ea);
		end else begin
			sa = {1'b0, fa} << (la + 5'd1);
			xa = 11'sd0 - 11'(la);
		end
		if (eb != 8'd0) begin
			sb = {1'b1, fb};
			xb = 11'(eb);
		end else begin
			sb = {1'b0, fb} << (lb + 5'd1);
			xb = 11'sd0 - 11'(lb);
		end
		unp.sign  = sign;
		unp.sig_a = sa;
		unp.sig_b = sb;
		unp.expo  = xa + xb - 11'(EXP_BIAS);
		unp.spc   = SPC_FIXED;
		priority if (a_nan) begin
			unp.fixed = operand_a | QUIET_BIT;
		end else if (b_nan) begin
			unp.fixed = operand_b | QUIET_BIT;
		end else if (a_inf || b_inf) begin
			unp.fixed = (a_zero || b_zero) ? DEFAULT_NAN : ({sign, 31'd0} | INF_BITS);
		end else if (a_zero || b_zero) begin
			unp.fixed = {sign, 31'd0};
		end else begin
			unp.fixed = 32'd0;
			unp.spc   = SPC_NONE;
		end
	end
endmodule

// ===== hdl/b32m_round.sv =====
// stage three: normalize, subnormal shift, round to nearest even, pack
module b32m_round import b32m_pkg::*; (
	input  mul_t        mul,
	output logic [31:0] result
);
	logic signed [10:0] e;
	logic [47:0] p, lostm;
	logic [5:0]  sh;
	logic [24:0] sig;
	logic [23:0] rem;
	logic [31:0] bits, sgn;

	always_comb begin
		sgn = {mul.sign, 31'd0};
		e = mul.expo;
		p = mul.prod;
		if (p[47]) begin
			e = e + 11'sd1;
		end else begin
			p = p << 1;
		end
		sh = 6'd0;
		if (e < 11'sd1 && e > -11'sd31) begin
			sh = 6'(11'sd1 - e);
		end
		lostm = (48'd1 << sh) - 48'd1;
		if (sh != 6'd0) begin
			p = (p >> sh) | {47'd0, |(p & lostm)};
		end
		sig = {1'b0, p[47:24]};
		rem = p[23:0];
		if (rem > 24'h80_0000 || (rem == 24'h80_0000 && sig[0])) begin
			sig = sig + 25'd1;
		end
		bits = (e >= 11'sd1) ? {e[8:0] - 9'd1, 23'd0} : 32'd0;
		bits = bits + {7'd0, sig};
		if (mul.spc == SPC_FIXED) begin
			result = mul.fixed;
		end else if (e >= 11'sd255) begin
			result = sgn | INF_BITS;
		end else if (e <= -11'sd31) begin
			result = sgn;
		end else if (bits >= INF_BITS) begin
			result = sgn | INF_BITS;
		end else begin
			result = sgn | bits;
		end
	end
endmodule

// ===== hdl/binary32_multiplier_unit.sv =====
// Pipelined IEEE-754 binary32 multiplier, round to nearest even, no flags.
// Input channel: valid/stall with operand_a and operand_b; an item is taken
// at a clock edge where valid is high and stall is low.
// Output channel: product_valid/product_stall with product_bits.
// Pipeline: unpack and normalize (stage 1), 24x24 significand product
// (stage 2), round and pack (stage 3, the output register).
// An accepted item is held in the stage 1, stage 2 and stage 3 registers in
// turn; product_valid rises once it reaches the stage 3 register.
// Throughput: one item per cycle while product_stall is low.
// When product_stall is high with a valid result waiting, the output stage
// holds; earlier items still move forward into empty stages, and stall is
// raised toward the sender only when all three stages hold an item.
// Reset (arst_n low) clears all valid bits asynchronously; no item is lost
// or invented across reset release.
module binary32_multiplier_unit import b32m_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        product_valid,
	input  logic        product_stall,
	output logic [31:0] product_bits
);
	unp_t        unp_c, unp_s1;
	mul_t        mul_s2;
	logic [31:0] res_c, res_s3;
	logic        v_s1, v_s2, v_s3;
	logic        en3, en2, en1;

	assign en3 = !v_s3 || !product_stall;
	assign en2 = en3 || !v_s2;
	assign en1 = en2 || !v_s1;
	assign stall = !en1;

	b32m_unpack u_unpack (.operand_a(operand_a), .operand_b(operand_b), .unp(unp_c));
	b32m_round  u_round  (.mul(mul_s2), .result(res_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) unp_s1 <= unp_c;
		if (en2) begin
			mul_s2.sign  <= unp_s1.sign;
			mul_s2.spc   <= unp_s1.spc;
			mul_s2.fixed <= unp_s1.fixed;
			mul_s2.expo  <= unp_s1.expo;
			mul_s2.prod  <= unp_s1.sig_a * unp_s1.sig_b;
		end
		if (en3) res_s3 <= res_c;
	end

	assign product_valid = v_s3;
	assign product_bits  = res_s3;

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		product_valid && product_stall |=> product_valid && $stable(product_bits))
		else $error("result changed while stalled");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> v_s1 && v_s2 && v_s3 && product_stall)
		else $error("stall raised with room in pipeline");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !product_stall |=> product_valid)
		else $error("item lost between stages");
`endif
endmodule
